@@ rtl/sqtm_pkg.sv @@
// sqtm_pkg: widths, operation codes and the control/status bundles of the
// squarified treemap layout block; used by every other file of the block
package sqtm_pkg;

  // field widths of the item and rectangle channels
  localparam int WEIGHT_W   = 48;
  localparam int ID_W       = 22;
  localparam int GEO_W      = 17;
  localparam int FRAC_BITS  = 16;

  // scaled weight width and derived arithmetic widths
  localparam int SCALE_BITS = 20;
  localparam int DVD_W      = SCALE_BITS + FRAC_BITS + 1;
  localparam int RAT_W      = 2 * SCALE_BITS + FRAC_BITS + 1;
  localparam int CROSS_W    = 2 * RAT_W;
  localparam int MUL_W      = 64;
  localparam int PROD_W     = 2 * MUL_W;

  // side of the unit square
  localparam logic [GEO_W-1:0] UNIT = GEO_W'(1) << FRAC_BITS;

  // multiplier jobs: operand pair and destination register
  typedef enum logic [3:0] {
    MUL_TM,   // total * short side
    MUL_AMX,  // (total * short side) * row max
    MUL_AMN,  // (total * short side) * row min
    MUL_BS,   // long side * row sum
    MUL_BB,   // (long side * row sum) * row sum
    MUL_PP,   // choose-ratio product, left
    MUL_QQ,   // choose-ratio product, right
    MUL_X1,   // cur num * prev den
    MUL_X2,   // prev num * cur den
    MUL_SL,   // row sum * crossed side
    MUL_CS    // running sum * row side
  } mul_op_t;

  // divider jobs
  typedef enum logic {
    DIV_T,    // row thickness, divide by remaining total
    DIV_O     // item offset, divide by row sum
  } div_op_t;

  // datapath register actions
  typedef enum logic [4:0] {
    A_NONE,
    A_SH_INIT,
    A_SHIFT,
    A_TOT_INIT,
    A_RD_POS,
    A_RD_END,
    A_RD_IDX,
    A_TOT_ADD,
    A_ROW_INIT,
    A_CAND,
    A_SEL,
    A_SEL_PREV,
    A_ACCEPT,
    A_EMIT_INIT,
    A_C_ADD,
    A_O_ZERO,
    A_EMIT,
    A_ZERO_EMIT,
    A_ROW_END,
    A_EMPTY,
    A_CLEAR
  } act_t;

  typedef struct packed {
    act_t    act;
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    div_op_t div_op;
  } dp_cmd_t;

  typedef struct packed {
    logic full_zero;
    logic sh_more;
    logic idx_n;
    logic idx_end;
    logic pos_end;
    logic end_n;
    logic tot_zero;
    logic winf;
    logic any_inf;
    logic greater;
    logic s_zero;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/sqtm_item_if.sv @@
// sqtm_item_if: input channel carrying one weighted item
// depends on sqtm_pkg
interface sqtm_item_if import sqtm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [ID_W-1:0]     item_id;
  logic                last_item;

  modport source (output valid, weight, item_id, last_item, input ready);
  modport sink   (input valid, weight, item_id, last_item, output ready);
endinterface

@@ rtl/sqtm_rect_if.sv @@
// sqtm_rect_if: output channel carrying one laid-out rectangle
// depends on sqtm_pkg
interface sqtm_rect_if import sqtm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  rect_id;
  logic [GEO_W-1:0] rect_x;
  logic [GEO_W-1:0] rect_y;
  logic [GEO_W-1:0] rect_w;
  logic [GEO_W-1:0] rect_h;
  logic             is_empty;
  logic             last_rect;

  modport source (output valid, rect_id, rect_x, rect_y, rect_w, rect_h, is_empty,
                  last_rect, input ready);
  modport sink   (input valid, rect_id, rect_x, rect_y, rect_w, rect_h, is_empty,
                  last_rect, output ready);
endinterface

@@ rtl/sqtm_mul.sv @@
// sqtm_mul: 64 x 64 multiplier built from one 32 x 32 partial product a cycle
// depends on sqtm_pkg
module sqtm_mul import sqtm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p,
  output logic              done
);
  localparam int HW = MUL_W / 2;

  logic [MUL_W-1:0]  ar;
  logic [MUL_W-1:0]  br;
  logic [2:0]        step;
  logic              busy;
  logic [MUL_W-1:0]  pp;
  logic [1:0]        ppk;
  logic              ppv;
  logic [PROD_W-1:0] acc;
  logic [HW-1:0]     ah;
  logic [HW-1:0]     bh;

  // half-word selection for the current partial product
  assign ah = step[1] ? ar[MUL_W-1:HW] : ar[HW-1:0];
  assign bh = step[0] ? br[MUL_W-1:HW] : br[HW-1:0];
  assign p  = acc;

  // partial product register, then shifted accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ppv  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ppv) begin
        acc <= acc + (PROD_W'(pp) << (HW * ppk));
      end
      if (start) begin
        ar   <= a;
        br   <= b;
        step <= 3'd0;
        busy <= 1'b1;
        acc  <= '0;
        ppv  <= 1'b0;
      end else if (busy) begin
        if (!step[2]) begin
          pp   <= MUL_W'(ah) * MUL_W'(bh);
          ppk  <= {1'b0, step[1]} + {1'b0, step[0]};
          ppv  <= 1'b1;
          step <= step + 3'd1;
        end else begin
          ppv  <= 1'b0;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/sqtm_div.sv @@
// sqtm_div: restoring divider, one quotient bit a cycle
// depends on sqtm_pkg
module sqtm_div import sqtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [SCALE_BITS-1:0] divisor,
  output logic [DVD_W-1:0]      quotient,
  output logic                  done
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [SCALE_BITS-1:0] d;
  logic [SCALE_BITS-1:0] r;
  logic [SCALE_BITS:0]   trial;
  logic [CW-1:0]         cnt;
  logic                  busy;

  assign trial = {r, quotient[DVD_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        d        <= divisor;
        r        <= '0;
        cnt      <= CW'(DVD_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          r        <= SCALE_BITS'(trial - {1'b0, d});
          quotient <= {quotient[DVD_W-2:0], 1'b1};
        end else begin
          r        <= trial[SCALE_BITS-1:0];
          quotient <= {quotient[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/sqtm_dp.sv @@
// sqtm_dp: item stores, layout registers, shared multiplier and divider,
// result register; depends on sqtm_pkg, sqtm_mul, sqtm_div
module sqtm_dp import sqtm_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [ID_W-1:0]     in_id,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                out_fire,
  output logic                out_valid,
  output logic [ID_W-1:0]     rect_id,
  output logic [GEO_W-1:0]    rect_x,
  output logic [GEO_W-1:0]    rect_y,
  output logic [GEO_W-1:0]    rect_w,
  output logic [GEO_W-1:0]    rect_h,
  output logic                is_empty,
  output logic                last_rect
);
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int FULL_W = WEIGHT_W + IDX_W;
  localparam int SH_W   = $clog2(FULL_W + 1);
  localparam int SW     = SCALE_BITS;

  // item stores
  logic [WEIGHT_W-1:0] wmem [MAX_ITEMS];
  logic [ID_W-1:0]     imem [MAX_ITEMS];
  logic [WEIGHT_W-1:0] q_w;
  logic [ID_W-1:0]     q_id;
  logic [IDX_W-1:0]    rd_idx;

  // load and scaling state
  logic [CNT_W-1:0]  cnt;
  logic [FULL_W-1:0] full;
  logic [FULL_W-1:0] shv;
  logic [SH_W-1:0]   sh;
  logic [SW-1:0]     tot;
  logic [SW-1:0]     v;

  // row state
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] endi;
  logic [CNT_W-1:0] idx;
  logic [SW-1:0]    s, mx, mn;
  logic [SW-1:0]    ws, wmx, wmn;
  logic [SW-1:0]    c;
  logic [GEO_W-1:0] fx, fy, fw, fh;
  logic [GEO_W-1:0] t, o0, o1;

  // ratio work registers
  logic [DVD_W-1:0]   tm, bs, dvd;
  logic [RAT_W-1:0]   fa, fa2, fb;
  logic [CROSS_W-1:0] p1, p2;
  logic [RAT_W-1:0]   cur_num, cur_den, prev_num, prev_den;
  logic               cur_inf, prev_inf;

  // shared units
  mul_op_t           mul_op_q;
  div_op_t           div_op_q;
  logic [MUL_W-1:0]  ma, mb;
  logic [PROD_W-1:0] mp;
  logic              mdone;
  logic [SW-1:0]     dsor;
  logic [DVD_W-1:0]  quo;
  logic              ddone;

  // free rectangle geometry
  logic             across;
  logic [GEO_W-1:0] m_side, big_side, lng, side;
  logic             idx_last;

  assign v        = SW'(q_w >> sh);
  assign across   = fw >= fh;
  assign m_side   = (fw < fh) ? fw : fh;
  assign big_side = (fw < fh) ? fh : fw;
  assign lng      = across ? fw : fh;
  assign side     = across ? fh : fw;
  assign idx_last = (idx + CNT_W'(1)) == cnt;

  // status to the controller
  always_comb begin
    stat.full_zero = full == '0;
    stat.sh_more   = |shv[FULL_W-1:SW];
    stat.idx_n     = idx == cnt;
    stat.idx_end   = idx == endi;
    stat.pos_end   = pos == cnt;
    stat.end_n     = endi == cnt;
    stat.tot_zero  = tot == '0;
    stat.winf      = (ws == '0) || (m_side == '0) || (wmn == '0) || (tot == '0);
    stat.any_inf   = cur_inf || prev_inf;
    stat.greater   = cur_inf ? !prev_inf : (!prev_inf && (p1 > p2));
    stat.s_zero    = s == '0;
    stat.mul_done  = mdone;
    stat.div_done  = ddone;
    stat.out_busy  = out_valid;
  end

  // store write on load, registered read for layout
  always_ff @(posedge clk) begin
    if (in_fire && (cnt < CNT_W'(MAX_ITEMS))) begin
      wmem[cnt[IDX_W-1:0]] <= in_weight;
      imem[cnt[IDX_W-1:0]] <= in_id;
    end
    q_w  <= wmem[rd_idx];
    q_id <= imem[rd_idx];
  end

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MUL_TM:  begin ma = MUL_W'(tot);      mb = MUL_W'(m_side);   end
      MUL_AMX: begin ma = MUL_W'(tm);       mb = MUL_W'(wmx);      end
      MUL_AMN: begin ma = MUL_W'(tm);       mb = MUL_W'(wmn);      end
      MUL_BS:  begin ma = MUL_W'(big_side); mb = MUL_W'(ws);       end
      MUL_BB:  begin ma = MUL_W'(bs);       mb = MUL_W'(ws);       end
      MUL_PP:  begin ma = MUL_W'(fa);       mb = MUL_W'(fa2);      end
      MUL_QQ:  begin ma = MUL_W'(fb);       mb = MUL_W'(fb);       end
      MUL_X1:  begin ma = MUL_W'(cur_num);  mb = MUL_W'(prev_den); end
      MUL_X2:  begin ma = MUL_W'(prev_num); mb = MUL_W'(cur_den);  end
      MUL_SL:  begin ma = MUL_W'(s);        mb = MUL_W'(lng);      end
      MUL_CS:  begin ma = MUL_W'(c);        mb = MUL_W'(side);     end
      default: begin ma = '0;               mb = '0;               end
    endcase
  end

  assign dsor = (cmd.div_op == DIV_T) ? tot : s;

  sqtm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .p     (mp),
    .done  (mdone)
  );

  sqtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsor),
    .quotient (quo),
    .done     (ddone)
  );

  // layout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      full      <= '0;
      pos       <= '0;
      fx        <= '0;
      fy        <= '0;
      fw        <= UNIT;
      fh        <= UNIT;
      out_valid <= 1'b0;
    end else begin
      // item load
      if (in_fire && (cnt < CNT_W'(MAX_ITEMS))) begin
        cnt  <= cnt + CNT_W'(1);
        full <= full + FULL_W'(in_weight);
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (cmd.mul_start) begin
        mul_op_q <= cmd.mul_op;
      end
      if (cmd.div_start) begin
        div_op_q <= cmd.div_op;
      end

      case (cmd.act)
        A_SH_INIT: begin
          shv <= full;
          sh  <= '0;
        end
        A_SHIFT: begin
          shv <= shv >> 1;
          sh  <= sh + SH_W'(1);
        end
        A_TOT_INIT: begin
          idx <= '0;
          tot <= '0;
        end
        A_RD_POS: rd_idx <= pos[IDX_W-1:0];
        A_RD_END: rd_idx <= endi[IDX_W-1:0];
        A_RD_IDX: rd_idx <= idx[IDX_W-1:0];
        A_TOT_ADD: begin
          tot <= tot + v;
          idx <= idx + CNT_W'(1);
        end
        A_ROW_INIT: begin
          s    <= v;
          mx   <= v;
          mn   <= v;
          ws   <= v;
          wmx  <= v;
          wmn  <= v;
          endi <= pos + CNT_W'(1);
        end
        A_CAND: begin
          ws  <= s + v;
          wmx <= (v > mx) ? v : mx;
          wmn <= (v < mn) ? v : mn;
        end
        A_SEL, A_SEL_PREV: begin
          // worst ratio of the candidate row
          if (stat.winf) begin
            cur_inf <= 1'b1;
          end else if (p1 >= p2) begin
            cur_inf <= 1'b0;
            cur_num <= fa;
            cur_den <= fb;
          end else begin
            cur_inf <= 1'b0;
            cur_num <= fb;
            cur_den <= fa2;
          end
          if (cmd.act == A_SEL_PREV) begin
            if (stat.winf) begin
              prev_inf <= 1'b1;
            end else if (p1 >= p2) begin
              prev_inf <= 1'b0;
              prev_num <= fa;
              prev_den <= fb;
            end else begin
              prev_inf <= 1'b0;
              prev_num <= fb;
              prev_den <= fa2;
            end
          end
        end
        A_ACCEPT: begin
          s        <= ws;
          mx       <= wmx;
          mn       <= wmn;
          prev_inf <= cur_inf;
          prev_num <= cur_num;
          prev_den <= cur_den;
          endi     <= endi + CNT_W'(1);
        end
        A_EMIT_INIT: begin
          idx <= pos;
          o0  <= '0;
          c   <= '0;
        end
        A_C_ADD:  c  <= c + v;
        A_O_ZERO: o1 <= '0;
        A_EMIT: begin
          out_valid <= 1'b1;
          rect_id   <= q_id;
          is_empty  <= 1'b0;
          last_rect <= idx_last;
          if (across) begin
            rect_x <= fx;
            rect_y <= fy + o0;
            rect_w <= t;
            rect_h <= o1 - o0;
          end else begin
            rect_x <= fx + o0;
            rect_y <= fy;
            rect_w <= o1 - o0;
            rect_h <= t;
          end
          o0  <= o1;
          idx <= idx + CNT_W'(1);
        end
        A_ZERO_EMIT: begin
          out_valid <= 1'b1;
          rect_id   <= q_id;
          rect_x    <= fx;
          rect_y    <= fy;
          rect_w    <= '0;
          rect_h    <= '0;
          is_empty  <= 1'b0;
          last_rect <= idx_last;
          idx       <= idx + CNT_W'(1);
        end
        A_ROW_END: begin
          if (across) begin
            fx <= fx + t;
            fw <= fw - t;
          end else begin
            fy <= fy + t;
            fh <= fh - t;
          end
          tot <= tot - s;
          pos <= endi;
        end
        A_EMPTY: begin
          out_valid <= 1'b1;
          rect_id   <= '0;
          rect_x    <= '0;
          rect_y    <= '0;
          rect_w    <= '0;
          rect_h    <= '0;
          is_empty  <= 1'b1;
          last_rect <= 1'b1;
        end
        A_CLEAR: begin
          cnt  <= '0;
          full <= '0;
          pos  <= '0;
          fx   <= '0;
          fy   <= '0;
          fw   <= UNIT;
          fh   <= UNIT;
        end
        default: ;
      endcase

      // multiplier result write-back
      if (mdone) begin
        case (mul_op_q)
          MUL_TM:          tm  <= mp[DVD_W-1:0];
          MUL_AMX:         fa  <= mp[RAT_W-1:0];
          MUL_AMN:         fa2 <= mp[RAT_W-1:0];
          MUL_BS:          bs  <= mp[DVD_W-1:0];
          MUL_BB:          fb  <= mp[RAT_W-1:0];
          MUL_PP, MUL_X1:  p1  <= mp[CROSS_W-1:0];
          MUL_QQ, MUL_X2:  p2  <= mp[CROSS_W-1:0];
          MUL_SL, MUL_CS:  dvd <= mp[DVD_W-1:0];
          default: ;
        endcase
      end

      // divider result write-back
      if (ddone) begin
        if (div_op_q == DIV_T) begin
          t <= quo[GEO_W-1:0];
        end else begin
          o1 <= quo[GEO_W-1:0];
        end
      end
    end
  end
endmodule

@@ rtl/sqtm_ctrl.sv @@
// sqtm_ctrl: sequencer for load, scaling, row building and rectangle output
// depends on sqtm_pkg
module sqtm_ctrl import sqtm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     in_last,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);
  localparam int ST_W = 37;

  typedef enum logic [ST_W-1:0] {
    S_LOAD      = ST_W'(1) << 0,
    S_SH_INIT   = ST_W'(1) << 1,
    S_SHIFT     = ST_W'(1) << 2,
    S_TOT_RD    = ST_W'(1) << 3,
    S_TOT_WAIT  = ST_W'(1) << 4,
    S_TOT_ADD   = ST_W'(1) << 5,
    S_ROW_TOP   = ST_W'(1) << 6,
    S_ROW_WAIT  = ST_W'(1) << 7,
    S_ROW_INIT  = ST_W'(1) << 8,
    S_W_TM      = ST_W'(1) << 9,
    S_W_AMX     = ST_W'(1) << 10,
    S_W_AMN     = ST_W'(1) << 11,
    S_W_BS      = ST_W'(1) << 12,
    S_W_BB      = ST_W'(1) << 13,
    S_W_PP      = ST_W'(1) << 14,
    S_W_QQ      = ST_W'(1) << 15,
    S_W_SEL     = ST_W'(1) << 16,
    S_CMP_X1    = ST_W'(1) << 17,
    S_CMP_X2    = ST_W'(1) << 18,
    S_CMP_DEC   = ST_W'(1) << 19,
    S_CAND_TOP  = ST_W'(1) << 20,
    S_CAND_WAIT = ST_W'(1) << 21,
    S_CAND_LOAD = ST_W'(1) << 22,
    S_T_MUL     = ST_W'(1) << 23,
    S_T_DIV     = ST_W'(1) << 24,
    S_E_RD      = ST_W'(1) << 25,
    S_E_WAIT    = ST_W'(1) << 26,
    S_E_CADD    = ST_W'(1) << 27,
    S_E_MUL     = ST_W'(1) << 28,
    S_E_DIV     = ST_W'(1) << 29,
    S_E_OUT     = ST_W'(1) << 30,
    S_ROW_END   = ST_W'(1) << 31,
    S_Z_RD      = ST_W'(1) << 32,
    S_Z_WAIT    = ST_W'(1) << 33,
    S_Z_OUT     = ST_W'(1) << 34,
    S_EMPTY     = ST_W'(1) << 35,
    S_CLEAR     = ST_W'(1) << 36
  } state_t;

  state_t state, state_next;
  logic   wait_q, wait_q_next;
  logic   row_start, row_start_next;

  // next state and commands
  always_comb begin
    state_next     = state;
    row_start_next = row_start;
    in_ready       = 1'b0;
    cmd.act        = A_NONE;
    cmd.mul_start  = 1'b0;
    cmd.mul_op     = MUL_TM;
    cmd.div_start  = 1'b0;
    cmd.div_op     = DIV_T;

    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_fire && in_last) state_next = S_SH_INIT;
      end
      S_SH_INIT: begin
        if (stat.full_zero) begin
          state_next = S_EMPTY;
        end else begin
          cmd.act    = A_SH_INIT;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.sh_more) begin
          cmd.act = A_SHIFT;
        end else begin
          cmd.act    = A_TOT_INIT;
          state_next = S_TOT_RD;
        end
      end
      S_TOT_RD: begin
        if (stat.idx_n) begin
          state_next = S_ROW_TOP;
        end else begin
          cmd.act    = A_RD_IDX;
          state_next = S_TOT_WAIT;
        end
      end
      S_TOT_WAIT: state_next = S_TOT_ADD;
      S_TOT_ADD: begin
        cmd.act    = A_TOT_ADD;
        state_next = S_TOT_RD;
      end
      S_ROW_TOP: begin
        if (stat.pos_end) begin
          state_next = S_CLEAR;
        end else if (stat.tot_zero) begin
          cmd.act    = A_EMIT_INIT;
          state_next = S_Z_RD;
        end else begin
          cmd.act    = A_RD_POS;
          state_next = S_ROW_WAIT;
        end
      end
      S_ROW_WAIT: state_next = S_ROW_INIT;
      S_ROW_INIT: begin
        cmd.act        = A_ROW_INIT;
        row_start_next = 1'b1;
        state_next     = S_W_TM;
      end
      // worst ratio of the row held in ws, wmx, wmn
      S_W_TM: begin
        if (stat.winf) begin
          state_next = S_W_SEL;
        end else begin
          cmd.mul_op    = MUL_TM;
          cmd.mul_start = !wait_q;
          if (stat.mul_done) state_next = S_W_AMX;
        end
      end
      S_W_AMX: begin
        cmd.mul_op    = MUL_AMX;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_AMN;
      end
      S_W_AMN: begin
        cmd.mul_op    = MUL_AMN;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_BS;
      end
      S_W_BS: begin
        cmd.mul_op    = MUL_BS;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_BB;
      end
      S_W_BB: begin
        cmd.mul_op    = MUL_BB;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_PP;
      end
      S_W_PP: begin
        cmd.mul_op    = MUL_PP;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_QQ;
      end
      S_W_QQ: begin
        cmd.mul_op    = MUL_QQ;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_W_SEL;
      end
      S_W_SEL: begin
        if (row_start) begin
          cmd.act    = A_SEL_PREV;
          state_next = S_CAND_TOP;
        end else begin
          cmd.act    = A_SEL;
          state_next = S_CMP_X1;
        end
      end
      // does the candidate make the row worse
      S_CMP_X1: begin
        if (stat.any_inf) begin
          state_next = S_CMP_DEC;
        end else begin
          cmd.mul_op    = MUL_X1;
          cmd.mul_start = !wait_q;
          if (stat.mul_done) state_next = S_CMP_X2;
        end
      end
      S_CMP_X2: begin
        cmd.mul_op    = MUL_X2;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_CMP_DEC;
      end
      S_CMP_DEC: begin
        if (stat.greater) begin
          state_next = S_T_MUL;
        end else begin
          cmd.act    = A_ACCEPT;
          state_next = S_CAND_TOP;
        end
      end
      S_CAND_TOP: begin
        if (stat.end_n) begin
          state_next = S_T_MUL;
        end else begin
          cmd.act    = A_RD_END;
          state_next = S_CAND_WAIT;
        end
      end
      S_CAND_WAIT: state_next = S_CAND_LOAD;
      S_CAND_LOAD: begin
        cmd.act        = A_CAND;
        row_start_next = 1'b0;
        state_next     = S_W_TM;
      end
      // row thickness
      S_T_MUL: begin
        cmd.mul_op    = MUL_SL;
        cmd.mul_start = !wait_q;
        if (stat.mul_done) state_next = S_T_DIV;
      end
      S_T_DIV: begin
        cmd.div_op    = DIV_T;
        cmd.div_start = !wait_q;
        if (stat.div_done) begin
          cmd.act    = A_EMIT_INIT;
          state_next = S_E_RD;
        end
      end
      // one rectangle per item of the row
      S_E_RD: begin
        if (stat.idx_end) begin
          state_next = S_ROW_END;
        end else begin
          cmd.act    = A_RD_IDX;
          state_next = S_E_WAIT;
        end
      end
      S_E_WAIT: state_next = S_E_CADD;
      S_E_CADD: begin
        cmd.act    = A_C_ADD;
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        if (stat.s_zero) begin
          cmd.act    = A_O_ZERO;
          state_next = S_E_OUT;
        end else begin
          cmd.mul_op    = MUL_CS;
          cmd.mul_start = !wait_q;
          if (stat.mul_done) state_next = S_E_DIV;
        end
      end
      S_E_DIV: begin
        cmd.div_op    = DIV_O;
        cmd.div_start = !wait_q;
        if (stat.div_done) state_next = S_E_OUT;
      end
      S_E_OUT: begin
        if (!stat.out_busy) begin
          cmd.act    = A_EMIT;
          state_next = S_E_RD;
        end
      end
      S_ROW_END: begin
        cmd.act    = A_ROW_END;
        state_next = S_ROW_TOP;
      end
      // remaining items once nothing is left to share out
      S_Z_RD: begin
        if (stat.idx_n) begin
          state_next = S_CLEAR;
        end else begin
          cmd.act    = A_RD_IDX;
          state_next = S_Z_WAIT;
        end
      end
      S_Z_WAIT: state_next = S_Z_OUT;
      S_Z_OUT: begin
        if (!stat.out_busy) begin
          cmd.act    = A_ZERO_EMIT;
          state_next = S_Z_RD;
        end
      end
      S_EMPTY: begin
        if (!stat.out_busy) begin
          cmd.act    = A_EMPTY;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.act    = A_CLEAR;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // outstanding unit job
  always_comb begin
    wait_q_next = wait_q;
    if (cmd.mul_start || cmd.div_start) begin
      wait_q_next = 1'b1;
    end else if (stat.mul_done || stat.div_done) begin
      wait_q_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      wait_q    <= 1'b0;
      row_start <= 1'b0;
    end else begin
      state     <= state_next;
      wait_q    <= wait_q_next;
      row_start <= row_start_next;
    end
  end
endmodule

@@ rtl/squarified_treemap_layout_top.sv @@
// channel  dir  handshake      payload
// items    in   valid/ready    weight[47:0] item_id[21:0] last_item
// rects    out  valid/ready    rect_id rect_x rect_y rect_w rect_h is_empty last_rect
//
// loading takes one item a cycle; the item marked last_item starts the layout
// scaling shifts the weight sum down to fit the scaled width, then adds up the scaled
// weights to form the total; layout time is set by the shared multiplier (up to 9
// products per candidate item) and the 37-step divider (at most one division per
// rectangle and one per row)
// synchronous reset returns to loading with an empty set and the unit square
// a stalled result holds the sequencer only when the next rectangle is ready
// depends on sqtm_pkg, sqtm_item_if, sqtm_rect_if, sqtm_ctrl, sqtm_dp
module squarified_treemap_layout_top import sqtm_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input logic         clk,
  input logic         rst,
  sqtm_item_if.sink   items,
  sqtm_rect_if.source rects
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     in_fire;
  logic     out_fire;

  assign items.ready = in_ready;
  assign in_fire     = items.valid && in_ready;
  assign out_fire    = rects.valid && rects.ready;

  sqtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (items.last_item),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sqtm_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_weight (items.weight),
    .in_id     (items.item_id),
    .cmd       (cmd),
    .stat      (stat),
    .out_fire  (out_fire),
    .out_valid (rects.valid),
    .rect_id   (rects.rect_id),
    .rect_x    (rects.rect_x),
    .rect_y    (rects.rect_y),
    .rect_w    (rects.rect_w),
    .rect_h    (rects.rect_h),
    .is_empty  (rects.is_empty),
    .last_rect (rects.last_rect)
  );

  // a multiplier job is issued once and not again until it finishes
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> !cmd.mul_start)
    else $error("multiplier restarted while busy");

  // only one arithmetic unit at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started together");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == A_EMIT || cmd.act == A_ZERO_EMIT || cmd.act == A_EMPTY)
      |-> !stat.out_busy)
    else $error("result register overwritten");
endmodule
